### hdl/nlmsc_pkg.sv
// nlmsc_pkg: shared types and fixed constants of the nlms sidelobe canceller
// used by nlmsc_cell, nlmsc_head, nlmsc_divider and nlms_sidelobe_canceller_unit
// no dependencies
`default_nettype none

package nlmsc_pkg;

    // register file
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int STEP_BITS      = 16;
    localparam int REG_BITS       = 16;

    localparam logic [STEP_BITS-1:0] STEP_RESET        = 16'd328;
    localparam logic [REG_BITS-1:0]  REGULARIZER_RESET = 16'd10737;
    localparam logic                 ADAPT_RESET       = 1'b1;
    localparam logic                 BLOCKING_RESET    = 1'b0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_STEP_SIZE    = 2'd0,
        CFG_REGULARIZER  = 2'd1,
        CFG_ADAPT_ENABLE = 2'd2,
        CFG_BLOCKING_SUB = 2'd3
    } cfg_index_t;

    // fixed-point format
    localparam int GAIN_FRAC       = 24;   // fraction bits of the nlms gain
    localparam int GAIN_BITS       = 32;   // signed gain, magnitude saturates at 2^31-1
    localparam int WEIGHT_INT_BITS = 4;    // weight fraction = weight bits - 4
    localparam int UPDATE_BASE     = STEP_BITS + GAIN_FRAC;
    localparam int ACC_BITS        = 64;
    localparam int ACC_LIMIT_LOG   = 62;   // accumulator clamps at +-2^62

    // cell row control
    typedef struct packed {
        logic rotate;   // take tap and weight from the upper neighbor
        logic push;     // take tap from the lower neighbor
    } cell_ctl_t;

    // shared multiply / update head control
    typedef struct packed {
        logic load;     // capture the element leaving cell 0
        logic update;   // gain * tap and weight update instead of weight * tap
    } head_ctl_t;

endpackage

`default_nettype wire

### hdl/nlmsc_cell.sv
// nlmsc_cell: one cell of the tap / weight row
// holds one tap and one weight; depends on nlmsc_pkg
`default_nettype none

module nlmsc_cell #(
    parameter int TAP_BITS    = 17,
    parameter int WEIGHT_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire nlmsc_pkg::cell_ctl_t          ctl,
    input  wire logic signed [TAP_BITS-1:0]    up_tap,
    input  wire logic signed [WEIGHT_BITS-1:0] up_weight,
    input  wire logic signed [TAP_BITS-1:0]    dn_tap,
    output logic signed [TAP_BITS-1:0]         tap,
    output logic signed [WEIGHT_BITS-1:0]      weight
);
    import nlmsc_pkg::*;

    logic signed [TAP_BITS-1:0]    tap_reg, tap_next;
    logic signed [WEIGHT_BITS-1:0] weight_reg, weight_next;

    always_comb
    begin
        tap_next    = tap_reg;
        weight_next = weight_reg;
        // rotate and push never come together; neither means hold
        if (ctl.rotate)
        begin
            tap_next    = up_tap;
            weight_next = up_weight;
        end
        else if (ctl.push)
        begin
            tap_next = dn_tap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg    <= '0;
            weight_reg <= '0;
        end
        else
        begin
            tap_reg    <= tap_next;
            weight_reg <= weight_next;
        end
    end

    assign tap    = tap_reg;
    assign weight = weight_reg;

endmodule

`default_nettype wire

### hdl/nlmsc_head.sv
// nlmsc_head: shared multiplier and weight update stage that closes the cell row
// takes the element leaving cell 0 and returns it to the last cell; depends on nlmsc_pkg
`default_nettype none

module nlmsc_head #(
    parameter int TAP_BITS    = 17,
    parameter int WEIGHT_BITS = 24
) (
    input  wire logic                                          clk,
    input  wire nlmsc_pkg::head_ctl_t                          ctl,
    input  wire logic signed [TAP_BITS-1:0]                    in_tap,
    input  wire logic signed [WEIGHT_BITS-1:0]                 in_weight,
    input  wire logic signed [nlmsc_pkg::GAIN_BITS-1:0]        gain,
    output logic signed [nlmsc_pkg::GAIN_BITS+TAP_BITS-1:0]    prod,
    output logic signed [TAP_BITS-1:0]                         ret_tap,
    output logic signed [WEIGHT_BITS-1:0]                      ret_weight
);
    import nlmsc_pkg::*;

    localparam int PROD_BITS = GAIN_BITS + TAP_BITS;
    localparam int UPD_SHIFT = UPDATE_BASE - (WEIGHT_BITS - WEIGHT_INT_BITS);
    localparam int SUM_BITS  = PROD_BITS + 2;

    localparam logic signed [PROD_BITS:0] ROUND_HALF =
        (PROD_BITS+1)'(1) <<< (UPD_SHIFT - 1);
    localparam logic signed [SUM_BITS-1:0] W_MAX =
        (SUM_BITS'(1) <<< (WEIGHT_BITS - 1)) - SUM_BITS'(1);
    localparam logic signed [SUM_BITS-1:0] W_MIN = -W_MAX - SUM_BITS'(1);

    logic signed [TAP_BITS-1:0]    p1_tap_reg, p1_tap_next;
    logic signed [WEIGHT_BITS-1:0] p1_weight_reg, p1_weight_next;
    logic signed [PROD_BITS-1:0]   p1_prod_reg, p1_prod_next;

    logic signed [GAIN_BITS-1:0]   op_a;
    logic signed [PROD_BITS:0]     p_rnd;
    logic signed [PROD_BITS:0]     delta;
    logic signed [SUM_BITS-1:0]    w_sum;
    logic signed [WEIGHT_BITS-1:0] w_sat;

    always_comb
    begin
        op_a           = ctl.update ? gain : GAIN_BITS'(in_weight);
        p1_tap_next    = p1_tap_reg;
        p1_weight_next = p1_weight_reg;
        p1_prod_next   = p1_prod_reg;
        if (ctl.load)
        begin
            p1_tap_next    = in_tap;
            p1_weight_next = in_weight;
            p1_prod_next   = PROD_BITS'(op_a) * PROD_BITS'(in_tap);
        end
    end

    // rounded floor shift of gain * tap, then saturating weight add
    always_comb
    begin
        p_rnd = (PROD_BITS+1)'(p1_prod_reg) + ROUND_HALF;
        delta = p_rnd >>> UPD_SHIFT;
        w_sum = SUM_BITS'(p1_weight_reg) + SUM_BITS'(delta);
        priority if (w_sum > W_MAX)
            w_sat = W_MAX[WEIGHT_BITS-1:0];
        else if (w_sum < W_MIN)
            w_sat = W_MIN[WEIGHT_BITS-1:0];
        else
            w_sat = w_sum[WEIGHT_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        p1_tap_reg    <= p1_tap_next;
        p1_weight_reg <= p1_weight_next;
        p1_prod_reg   <= p1_prod_next;
    end

    assign prod       = p1_prod_reg;
    assign ret_tap    = p1_tap_reg;
    assign ret_weight = ctl.update ? w_sat : p1_weight_reg;

endmodule

`default_nettype wire

### hdl/nlmsc_divider.sv
// nlmsc_divider: restoring divider, one quotient bit per cycle, for the nlms gain
// computes min(num * 2^GAIN_FRAC / den, 2^31-1); depends on nlmsc_pkg
`default_nettype none

module nlmsc_divider #(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 39
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [NUM_BITS-1:0]                 num,
    input  wire logic [DEN_BITS-1:0]                 den,
    output logic                                     done,
    output logic [nlmsc_pkg::GAIN_BITS-2:0]          qmag
);
    import nlmsc_pkg::*;

    localparam int STEPS    = NUM_BITS + GAIN_FRAC;
    localparam int CNT_BITS = $clog2(STEPS);
    localparam int Q_BITS   = GAIN_BITS - 1;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [NUM_BITS-1:0] num_reg, num_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [Q_BITS-1:0]   q_reg, q_next;
    logic                ovf_reg, ovf_next;

    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS+1:0] diff;
    logic                fits;

    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_BITS-1]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
        fits  = ~diff[DEN_BITS+1];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;

        priority if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = num;
            den_next  = den;
            q_next    = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            num_next = num_reg << 1;
            // quotient bits above bit 30 only mark saturation
            q_next   = {q_reg[Q_BITS-2:0], fits};
            ovf_next = ovf_reg | q_reg[Q_BITS-1];
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign qmag = ovf_reg ? '1 : q_reg;

endmodule

`default_nettype wire

### hdl/nlms_sidelobe_canceller_unit.sv
// nlms_sidelobe_canceller_unit: two-microphone sidelobe canceller with nlms weights
// top level; uses nlmsc_pkg, nlmsc_cell, nlmsc_head and nlmsc_divider
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+-----------
//  input    | in_valid, in_ready, mic_a, mic_b     | in
//  output   | out_valid, out_ready, error_out      | out
//  config   | cfg_write, cfg_index, cfg_data       | in, write only
//
// one sample pair at a time; with adaptation on, a beat makes two full rotations of the
// cell row through the shared multiplier (dot product, then weight update) and runs
// the one-bit-per-cycle gain divider; with it off, or with a zero gain denominator,
// only the dot-product rotation runs
// the error beat waits in its output register; a full register stalls only the error step
// reset clears taps, weights, energy and loads the register defaults
`default_nettype none

module nlms_sidelobe_canceller_unit #(
    parameter int TAP_COUNT   = 32,
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 24
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]         mic_a,
    input  wire logic signed [SAMPLE_BITS-1:0]         mic_b,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [SAMPLE_BITS-1:0]              error_out,
    input  wire logic                                  cfg_write,
    input  wire logic [nlmsc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [nlmsc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import nlmsc_pkg::*;

    localparam int TAP_BITS    = SAMPLE_BITS + 1;
    localparam int ENERGY_BITS = 2 * SAMPLE_BITS + $clog2(TAP_COUNT) + 1;
    localparam int DEN_BITS    = ENERGY_BITS + 1;
    localparam int NUM_BITS    = STEP_BITS + SAMPLE_BITS;
    localparam int PROD_BITS   = GAIN_BITS + TAP_BITS;
    localparam int WEIGHT_FRAC = WEIGHT_BITS - WEIGHT_INT_BITS;
    localparam int CNT_BITS    = $clog2(TAP_COUNT + 1);
    localparam int SQ_BITS     = 2 * TAP_BITS;
    localparam int DIFF_BITS   = ACC_BITS + 1;

    localparam logic signed [ACC_BITS-1:0] ACC_HI  = ACC_BITS'(1) <<< ACC_LIMIT_LOG;
    localparam logic signed [ACC_BITS-1:0] ACC_LO  = -ACC_HI;
    localparam logic signed [ACC_BITS-1:0] ROUND_Y = ACC_BITS'(1) <<< (WEIGHT_FRAC - 1);
    localparam logic signed [DIFF_BITS-1:0] E_MAX  =
        (DIFF_BITS'(1) <<< (SAMPLE_BITS - 1)) - DIFF_BITS'(1);
    localparam logic signed [DIFF_BITS-1:0] E_MIN  = -E_MAX - DIFF_BITS'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INSERT,
        ST_DOT,
        ST_ROUND,
        ST_ERR,
        ST_GAIN,
        ST_DIV,
        ST_UPD
    } state_t;

    // control and state registers
    state_t                        state_reg, state_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] error_out_reg, error_out_next;
    logic [STEP_BITS-1:0]          step_reg, step_next;
    logic [REG_BITS-1:0]           regularizer_reg, regularizer_next;
    logic                          adapt_reg, adapt_next;
    logic                          blocking_reg, blocking_next;
    logic [ENERGY_BITS-1:0]        energy_reg, energy_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic                          pv_reg, pv_next;

    // datapath registers
    logic signed [TAP_BITS-1:0]    r_reg, r_next;
    logic signed [TAP_BITS-1:0]    u_reg, u_next;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic signed [ACC_BITS-1:0]    y_reg, y_next;
    logic signed [SAMPLE_BITS-1:0] e_reg, e_next;
    logic                          neg_reg, neg_next;
    logic signed [GAIN_BITS-1:0]   gain_reg, gain_next;

    // row and head wiring
    cell_ctl_t                     cell_ctl;
    head_ctl_t                     head_ctl;
    logic signed [TAP_BITS-1:0]    tap_q [TAP_COUNT];
    logic signed [WEIGHT_BITS-1:0] weight_q [TAP_COUNT];
    logic signed [PROD_BITS-1:0]   head_prod;
    logic signed [TAP_BITS-1:0]    ret_tap;
    logic signed [WEIGHT_BITS-1:0] ret_weight;

    // divider
    logic                          div_start;
    logic                          div_done;
    logic [GAIN_BITS-2:0]          div_qmag;
    logic [NUM_BITS-1:0]           num_c;
    logic [DEN_BITS-1:0]           den_c;

    // combinational helpers
    logic signed [TAP_BITS-1:0]    a_ext, b_ext;
    logic signed [SQ_BITS-1:0]     u_sq, o_sq;
    logic signed [ACC_BITS-1:0]    acc_sum;
    logic signed [DIFF_BITS-1:0]   e_diff;
    logic signed [SAMPLE_BITS-1:0] e_sat;
    logic [SAMPLE_BITS-1:0]        e_mag;
    logic signed [GAIN_BITS-1:0]   qm;

    genvar j;
    generate
        for (j = 0; j < TAP_COUNT; j++)
        begin : g_cell
            logic signed [TAP_BITS-1:0]    up_t;
            logic signed [WEIGHT_BITS-1:0] up_w;
            logic signed [TAP_BITS-1:0]    dn_t;

            // the head closes the row: cell 0 feeds it, it feeds the last cell
            if (j == TAP_COUNT - 1)
            begin : g_top
                assign up_t = ret_tap;
                assign up_w = ret_weight;
            end
            else
            begin : g_up
                assign up_t = tap_q[j+1];
                assign up_w = weight_q[j+1];
            end

            if (j == 0)
            begin : g_first
                assign dn_t = u_reg;
            end
            else
            begin : g_dn
                assign dn_t = tap_q[j-1];
            end

            nlmsc_cell #(
                .TAP_BITS    (TAP_BITS),
                .WEIGHT_BITS (WEIGHT_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (cell_ctl),
                .up_tap    (up_t),
                .up_weight (up_w),
                .dn_tap    (dn_t),
                .tap       (tap_q[j]),
                .weight    (weight_q[j])
            );
        end
    endgenerate

    nlmsc_head #(
        .TAP_BITS    (TAP_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_head (
        .clk        (clk),
        .ctl        (head_ctl),
        .in_tap     (tap_q[0]),
        .in_weight  (weight_q[0]),
        .gain       (gain_reg),
        .prod       (head_prod),
        .ret_tap    (ret_tap),
        .ret_weight (ret_weight)
    );

    nlmsc_divider #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (DEN_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_c),
        .den   (den_c),
        .done  (div_done),
        .qmag  (div_qmag)
    );

    always_comb
    begin
        a_ext = TAP_BITS'(mic_a);
        b_ext = TAP_BITS'(mic_b);
        u_sq  = SQ_BITS'(u_reg) * SQ_BITS'(u_reg);
        o_sq  = SQ_BITS'(tap_q[TAP_COUNT-1]) * SQ_BITS'(tap_q[TAP_COUNT-1]);

        acc_sum = acc_reg + ACC_BITS'(head_prod);

        e_diff = DIFF_BITS'(r_reg) - DIFF_BITS'(y_reg);
        priority if (e_diff > E_MAX)
            e_sat = E_MAX[SAMPLE_BITS-1:0];
        else if (e_diff < E_MIN)
            e_sat = E_MIN[SAMPLE_BITS-1:0];
        else
            e_sat = e_diff[SAMPLE_BITS-1:0];

        // most negative error maps to its unsigned magnitude
        e_mag = e_reg[SAMPLE_BITS-1] ? unsigned'(-e_reg) : unsigned'(e_reg);
        num_c = NUM_BITS'(step_reg) * NUM_BITS'(e_mag);
        den_c = DEN_BITS'(energy_reg) + DEN_BITS'(regularizer_reg);
        qm    = signed'({1'b0, div_qmag});
    end

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        error_out_next   = error_out_reg;
        step_next        = step_reg;
        regularizer_next = regularizer_reg;
        adapt_next       = adapt_reg;
        blocking_next    = blocking_reg;
        energy_next      = energy_reg;
        cnt_next         = cnt_reg;
        pv_next          = pv_reg;
        r_next           = r_reg;
        u_next           = u_reg;
        acc_next         = acc_reg;
        y_next           = y_reg;
        e_next           = e_reg;
        neg_next         = neg_reg;
        gain_next        = gain_reg;
        cell_ctl         = '0;
        head_ctl         = '0;
        div_start        = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_STEP_SIZE:    step_next        = cfg_data[STEP_BITS-1:0];
                CFG_REGULARIZER:  regularizer_next = cfg_data[REG_BITS-1:0];
                CFG_ADAPT_ENABLE: adapt_next       = cfg_data[0];
                CFG_BLOCKING_SUB: blocking_next    = cfg_data[0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    r_next     = a_ext + b_ext;
                    u_next     = blocking_reg ? (a_ext - b_ext) : (a_ext + b_ext);
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                cell_ctl.push = 1'b1;
                energy_next   = energy_reg + ENERGY_BITS'(unsigned'(u_sq))
                                - ENERGY_BITS'(unsigned'(o_sq));
                acc_next      = '0;
                pv_next       = 1'b0;
                cnt_next      = '0;
                state_next    = ST_DOT;
            end
            ST_DOT:
            begin
                // one full turn of the row plus the head slot, taps leave in index order
                cell_ctl.rotate = 1'b1;
                head_ctl.load   = 1'b1;
                pv_next         = (cnt_reg < CNT_BITS'(TAP_COUNT));
                if (pv_reg)
                begin
                    priority if (acc_sum > ACC_HI)
                        acc_next = ACC_HI;
                    else if (acc_sum < ACC_LO)
                        acc_next = ACC_LO;
                    else
                        acc_next = acc_sum;
                end
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(TAP_COUNT))
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                y_next     = (acc_reg + ROUND_Y) >>> WEIGHT_FRAC;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    e_next         = e_sat;
                    error_out_next = e_sat;
                    out_valid_next = 1'b1;
                    state_next     = adapt_reg ? ST_GAIN : ST_IDLE;
                end
            end
            ST_GAIN:
            begin
                if (den_c == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    neg_next   = e_reg[SAMPLE_BITS-1];
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    gain_next  = neg_reg ? -qm : qm;
                    cnt_next   = '0;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cell_ctl.rotate = 1'b1;
                head_ctl.load   = 1'b1;
                head_ctl.update = 1'b1;
                cnt_next        = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(TAP_COUNT))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            error_out_reg   <= '0;
            step_reg        <= STEP_RESET;
            regularizer_reg <= REGULARIZER_RESET;
            adapt_reg       <= ADAPT_RESET;
            blocking_reg    <= BLOCKING_RESET;
            energy_reg      <= '0;
            cnt_reg         <= '0;
            pv_reg          <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            error_out_reg   <= error_out_next;
            step_reg        <= step_next;
            regularizer_reg <= regularizer_next;
            adapt_reg       <= adapt_next;
            blocking_reg    <= blocking_next;
            energy_reg      <= energy_next;
            cnt_reg         <= cnt_next;
            pv_reg          <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        u_reg    <= u_next;
        acc_reg  <= acc_next;
        y_reg    <= y_next;
        e_reg    <= e_next;
        neg_reg  <= neg_next;
        gain_reg <= gain_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign error_out = error_out_reg;

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for nlms_sidelobe_canceller_unit, a directed script then random
// sample pairs, each error beat checked against a script value or an in-bench nlms model
// depends on nlmsc_pkg and nlms_sidelobe_canceller_unit

module tb_top;
    import nlmsc_pkg::*;

    localparam int TAPS        = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int WEIGHT_BITS = 24;
    localparam int WFRAC       = WEIGHT_BITS - WEIGHT_INT_BITS;
    localparam int UPD_SHIFT   = UPDATE_BASE - WFRAC;
    localparam int SETTLE      = 200;   // settle margin, above one full beat with adaptation
    localparam int PHASES      = 8;
    localparam int PHASE_PAIRS = 205;
    localparam int SCRIPT_LEN  = 26;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_KNOWN,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        cfg_index_t idx;
        logic [15:0] value;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [SAMPLE_BITS-1:0] mic_a = '0;
    logic signed [SAMPLE_BITS-1:0] mic_b = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] error_out;
    logic cfg_write = 1'b0;
    cfg_index_t cfg_index = CFG_STEP_SIZE;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // canceller model state and register shadows
    longint taps [TAPS];
    longint weights [TAPS];
    longint unsigned energy;
    logic [15:0] step_cfg = STEP_RESET;
    logic [15:0] reg_cfg = REGULARIZER_RESET;
    logic adapt_cfg = ADAPT_RESET;
    logic blocking_cfg = BLOCKING_RESET;

    logic signed [SAMPLE_BITS-1:0] pending_errors [$];
    logic signed [SAMPLE_BITS-1:0] want_error;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int samples_sent = 0;
    int errors_checked = 0;
    int failures = 0;
    int settings_applied = 0;
    script_row_t script [SCRIPT_LEN];

    nlms_sidelobe_canceller_unit #(
        .TAP_COUNT  (TAPS),
        .SAMPLE_BITS(SAMPLE_BITS),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mic_a    (mic_a),
        .mic_b    (mic_b),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .error_out(error_out),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint sat_to_bits(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // one sample pair through the canceller: shift, filter, error, nlms update
    function automatic logic signed [SAMPLE_BITS-1:0] cancel_sample(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b
    );
        longint ref_sum;
        longint blk;
        longint oldest;
        longint acc;
        longint acc_cap;
        longint y;
        longint err;
        longint q;
        longint d;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned num;
        longint unsigned qm;
        int j;
        ref_sum = longint'(a) + longint'(b);
        blk = blocking_cfg ? longint'(a) - longint'(b) : ref_sum;
        oldest = taps[TAPS-1];
        for (j = TAPS - 1; j > 0; j--)
            taps[j] = taps[j-1];
        taps[0] = blk;
        energy = energy + 64'(blk * blk) - 64'(oldest * oldest);

        acc_cap = longint'(1) <<< ACC_LIMIT_LOG;
        acc = 0;
        for (j = 0; j < TAPS; j++)
        begin
            acc = acc + weights[j] * taps[j];
            if (acc > acc_cap)
                acc = acc_cap;
            if (acc < -acc_cap)
                acc = -acc_cap;
        end
        y = (acc + (longint'(1) <<< (WFRAC - 1))) >>> WFRAC;
        err = sat_to_bits(ref_sum - y, SAMPLE_BITS);

        if (adapt_cfg)
        begin
            den = energy + 64'(reg_cfg);
            // all taps zero with no regularizer: weights stay put
            if (den != 0)
            begin
                mag = (err < 0) ? 64'(-err) : 64'(err);
                num = (64'(step_cfg) * mag) << GAIN_FRAC;
                qm = num / den;
                if (qm > 64'h7FFF_FFFF)
                    qm = 64'h7FFF_FFFF;
                q = (err < 0) ? -$signed(qm) : $signed(qm);
                for (j = 0; j < TAPS; j++)
                begin
                    d = (q * taps[j] + (longint'(1) <<< (UPD_SHIFT - 1))) >>> UPD_SHIFT;
                    weights[j] = sat_to_bits(weights[j] + d, WEIGHT_BITS);
                end
            end
        end
        return err[SAMPLE_BITS-1:0];
    endfunction

    function automatic script_row_t sample_row(input int a, input int b);
        return '{ROW_SAMPLE, CFG_STEP_SIZE, 16'd0, 16'(a), 16'(b), 16'd0};
    endfunction

    function automatic script_row_t known_row(input int a, input int b, input int want);
        return '{ROW_KNOWN, CFG_STEP_SIZE, 16'd0, 16'(a), 16'(b), 16'(want)};
    endfunction

    function automatic script_row_t write_row(input cfg_index_t idx, input int value);
        return '{ROW_WRITE, idx, 16'(value), 16'd0, 16'd0, 16'd0};
    endfunction

    // drop valid and wait until every error beat is back, then for the requested extra cycles
    task automatic settle(input int extra);
        in_valid <= 1'b0;
        while (pending_errors.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        settle(SETTLE);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_STEP_SIZE:    step_cfg = value;
            CFG_REGULARIZER:  reg_cfg = value;
            CFG_ADAPT_ENABLE: adapt_cfg = value[0];
            CFG_BLOCKING_SUB: blocking_cfg = value[0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic drive_sample(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b,
        input logic use_typed,
        input logic signed [SAMPLE_BITS-1:0] typed
    );
        logic signed [SAMPLE_BITS-1:0] predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mic_a <= a;
        mic_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = cancel_sample(a, b);
        pending_errors.push_back(use_typed ? typed : predicted);
        samples_sent++;
    endtask

    task automatic set_registers(input logic [15:0] step, input logic [15:0] regv,
                                 input logic adapt, input logic blocking);
        // random upper bits on the one-bit registers must be ignored
        write_reg(CFG_STEP_SIZE, step);
        write_reg(CFG_REGULARIZER, regv);
        write_reg(CFG_ADAPT_ENABLE, {15'($urandom), adapt});
        write_reg(CFG_BLOCKING_SUB, {15'($urandom), blocking});
        settings_applied++;
    endtask

    // error beat checker and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_errors.size() == 0)
            begin
                $error("error_out beat with nothing pending: actual %0d", error_out);
                failures++;
            end
            else
            begin
                want_error = pending_errors.pop_front();
                errors_checked++;
                if (error_out !== want_error)
                begin
                    $error("error_out mismatch: expected %0d, actual %0d", want_error, error_out);
                    failures++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #20_000_000;
        $display("** nlms_sidelobe_canceller_unit: FAILED **");
        $finish;
    end

    initial
    begin
        int corner_vals [5];
        int phase;
        int n;
        int r;
        int k;
        int burst;
        int a_val;
        int b_val;
        int s;
        int interf;
        int tri_pos;
        int paused;

        corner_vals = '{32767, -32768, 0, -1, 1};
        energy = 0;
        tri_pos = 0;
        paused = 0;
        for (k = 0; k < TAPS; k++)
        begin
            taps[k] = 0;
            weights[k] = 0;
        end

        script = '{
            write_row(CFG_REGULARIZER, 0),
            // zero denominator: empty line, no regularizer
            known_row(0, 0, 0),
            known_row(0, 0, 0),
            write_row(CFG_ADAPT_ENABLE, 16'hFFFE),
            // weights still zero, so the error is the saturated reference
            known_row(32767, 32767, 32767),
            known_row(-32768, -32768, -32768),
            known_row(32767, -32768, -1),
            known_row(-1, 1, 0),
            write_row(CFG_BLOCKING_SUB, 16'hFFFF),
            known_row(32767, -32768, -1),
            known_row(-32768, 32767, -1),
            write_row(CFG_STEP_SIZE, 65535),
            write_row(CFG_REGULARIZER, 65535),
            write_row(CFG_ADAPT_ENABLE, 1),
            known_row(1234, -4321, -3087),
            // max step drives gain and weights into saturation
            sample_row(32767, 32767),
            sample_row(-32768, -32768),
            sample_row(32767, -32768),
            sample_row(-32768, 32767),
            sample_row(0, 0),
            sample_row(-1, -1),
            sample_row(16384, 16383),
            write_row(CFG_STEP_SIZE, 0),
            write_row(CFG_BLOCKING_SUB, 0),
            sample_row(32767, 32767),
            sample_row(-32768, 100)
        };

        send_idle_pct = 19;
        recv_idle_pct = 62;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < SCRIPT_LEN; k++)
        begin
            case (script[k].kind)
                ROW_WRITE:
                    write_reg(script[k].idx, script[k].value);
                ROW_KNOWN:
                    drive_sample(script[k].a, script[k].b, 1'b1, script[k].want);
                default:
                    drive_sample(script[k].a, script[k].b, 1'b0, '0);
            endcase
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 62;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (phase)
                0: set_registers(STEP_RESET, REGULARIZER_RESET, 1'b1, 1'b0);
                1: set_registers(16'($urandom), 16'($urandom), 1'b1, 1'b1);
                2: set_registers(16'hFFFF, 16'd0, 1'b1, 1'($urandom));
                3: set_registers(16'd0, 16'hFFFF, 1'b1, 1'b0);
                4: set_registers(16'($urandom), 16'($urandom), 1'b0, 1'($urandom));
                5: set_registers(16'($urandom_range(4000, 1)), 16'($urandom), 1'b1, 1'b1);
                6: set_registers(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
                default: set_registers(16'($urandom), 16'd0, 1'b1, 1'b0);
            endcase

            n = 0;
            while (n < PHASE_PAIRS)
            begin
                if (phase == 1 && n >= PHASE_PAIRS / 2 && paused == 0)
                begin
                    settle(0);
                    paused = 1;
                end
                r = $urandom_range(99);
                if (r < 5)
                begin
                    // long silence empties the line and the window energy
                    burst = 33 + $urandom_range(7);
                    for (k = 0; k < burst; k++)
                        drive_sample('0, '0, 1'b0, '0);
                    n += burst;
                end
                else
                begin
                    if (r < 45)
                    begin
                        a_val = int'($urandom);
                        b_val = int'($urandom);
                    end
                    else if (r < 75)
                    begin
                        // common target plus a triangle interferer, opposite in the two mics
                        tri_pos = (tri_pos + 1) % 64;
                        interf = ((tri_pos < 32) ? tri_pos : 63 - tri_pos) * 900 - 14400;
                        s = int'($urandom_range(4000)) - 2000;
                        a_val = int'(sat_to_bits(s + interf, SAMPLE_BITS));
                        b_val = int'(sat_to_bits(s - interf, SAMPLE_BITS));
                    end
                    else if (r < 90)
                    begin
                        a_val = int'($urandom_range(510)) - 255;
                        b_val = int'($urandom_range(510)) - 255;
                    end
                    else
                    begin
                        a_val = corner_vals[$urandom_range(4)];
                        b_val = corner_vals[$urandom_range(4)];
                    end
                    drive_sample(16'(a_val), 16'(b_val), 1'b0, '0);
                    n++;
                end
            end
        end

        settle(SETTLE);
        $display("run covered %0d sample pairs over %0d random register settings plus the script",
                 samples_sent, settings_applied);
        $display("%0d error beats compared, %0d mismatches", errors_checked, failures);
        if (failures == 0)
            $display("** nlms_sidelobe_canceller_unit: PASSED **");
        else
            $display("** nlms_sidelobe_canceller_unit: FAILED **");
        $finish;
    end

endmodule
